// ===== hw/rtl/utf8f_pkg.sv =====
// Shared types and constants for the UTF-8 to fixed ASCII field converter.
`timescale 1ns / 1ps

package utf8f_pkg;

   localparam int CNT_W  = 7;
   localparam int ACC_W  = 21;
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [7:0]       CHAR_REPLACE = 8'h3F;
   localparam logic [7:0]       CHAR_SPACE   = 8'h20;
   localparam logic [CNT_W-1:0] WIDTH_RESET  = 7'd64;

   // One queued command: an optional decoded byte, then an optional run of padding.
   typedef struct packed {
      logic             has_char;
      logic [7:0]       char_byte;
      logic             char_last;
      logic             has_pad;
      logic [CNT_W-1:0] pad_start;
      logic [CNT_W-1:0] width;
   } cmd_type;

endpackage

// ===== hw/rtl/utf8f_front.sv =====
// Front end: accepts bytes, tracks UTF-8 windows and field position, issues commands.
`timescale 1ns / 1ps

module utf8f_front
   import utf8f_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] eff_width,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_in_byte,
   input  logic             req_has_byte,
   input  logic             req_end_of_field,
   input  logic             q_full,
   output logic             q_push,
   output cmd_type          q_data
);

   logic [1:0]       pending_ff, pending_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             bad_ff, bad_in;
   logic [CNT_W-1:0] written_ff, written_in;

   logic             accept;
   logic             take;
   logic             emit;
   logic [7:0]       emit_byte;
   logic [CNT_W-1:0] written_after;
   logic [ACC_W-1:0] acc_shift;
   logic             bad_next;
   logic [1:0]       pending_dec;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign take      = req_has_byte && (written_ff < eff_width);
   assign acc_shift = {acc_ff[ACC_W-7:0], req_in_byte[5:0]};
   assign bad_next  = bad_ff || (req_in_byte[7:6] != 2'b10);
   assign pending_dec = pending_ff - 2'd1;

   always_comb begin
      pending_in = pending_ff;
      acc_in     = acc_ff;
      bad_in     = bad_ff;
      emit       = 1'b0;
      emit_byte  = CHAR_REPLACE;
      if (take) begin
         if (pending_ff == 2'd0) begin
            if (!req_in_byte[7]) begin
               emit      = 1'b1;
               emit_byte = req_in_byte;
            end else if (req_in_byte[7:5] == 3'b110) begin
               acc_in     = ACC_W'(req_in_byte[4:0]);
               pending_in = 2'd1;
               bad_in     = 1'b0;
            end else if (req_in_byte[7:4] == 4'b1110) begin
               acc_in     = ACC_W'(req_in_byte[3:0]);
               pending_in = 2'd2;
               bad_in     = 1'b0;
            end else if (req_in_byte[7:3] == 5'b11110) begin
               acc_in     = ACC_W'(req_in_byte[2:0]);
               pending_in = 2'd3;
               bad_in     = 1'b0;
            end else begin
               emit = 1'b1;
            end
         end else begin
            acc_in     = acc_shift;
            bad_in     = bad_next;
            pending_in = pending_dec;
            if (pending_dec == 2'd0) begin
               emit = 1'b1;
               if (!bad_next && (acc_shift <= ACC_W'(8'h7F))) begin
                  emit_byte = acc_shift[7:0];
               end
            end
         end
      end
      written_after = written_ff + CNT_W'(emit);
      written_in    = written_after;
      if (req_end_of_field) begin
         pending_in = 2'd0;
         acc_in     = '0;
         bad_in     = 1'b0;
         written_in = '0;
      end
   end

   always_comb begin
      q_data.has_char  = emit;
      q_data.char_byte = emit_byte;
      q_data.char_last = (written_after == eff_width);
      q_data.has_pad   = req_end_of_field && (written_after < eff_width);
      q_data.pad_start = written_after;
      q_data.width     = eff_width;
   end

   assign q_push = accept && (q_data.has_char || q_data.has_pad);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         acc_ff     <= '0;
         bad_ff     <= 1'b0;
         written_ff <= '0;
      end else if (accept) begin
         pending_ff <= pending_in;
         acc_ff     <= acc_in;
         bad_ff     <= bad_in;
         written_ff <= written_in;
      end
   end

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into full queue");

endmodule

// ===== hw/rtl/utf8f_queue.sv =====
// Small command queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module utf8f_queue
   import utf8f_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QDEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count above depth");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

// ===== hw/rtl/utf8f_back.sv =====
// Back end: plays out queued commands as field bytes into the output register.
`timescale 1ns / 1ps

module utf8f_back
   import utf8f_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic             rsp_valid_ff;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             char_done_ff, char_done_in;
   logic             pad_busy_ff, pad_busy_in;
   logic [CNT_W-1:0] pad_pos_ff, pad_pos_in;

   logic             load;
   logic [CNT_W-1:0] pos;
   logic [CNT_W-1:0] pos_next;

   assign load     = !rsp_valid_ff || !rsp_stall;
   assign pos      = pad_busy_ff ? pad_pos_ff : head.pad_start;
   assign pos_next = pos + CNT_W'(1);

   always_comb begin
      pop          = 1'b0;
      byte_in      = CHAR_SPACE;
      last_in      = 1'b0;
      char_done_in = char_done_ff;
      pad_busy_in  = pad_busy_ff;
      pad_pos_in   = pad_pos_ff;
      if (load && !empty) begin
         if (head.has_char && !char_done_ff) begin
            byte_in = head.char_byte;
            last_in = head.char_last;
            if (head.has_pad) begin
               char_done_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            last_in = (pos_next == head.width);
            if (last_in) begin
               pop          = 1'b1;
               char_done_in = 1'b0;
               pad_busy_in  = 1'b0;
            end else begin
               pad_busy_in = 1'b1;
               pad_pos_in  = pos_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         char_done_ff <= 1'b0;
         pad_busy_ff  <= 1'b0;
         pad_pos_ff   <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= !empty;
         end
         char_done_ff <= char_done_in;
         pad_busy_ff  <= pad_busy_in;
         pad_pos_ff   <= pad_pos_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

   a_pad_in_field: assert property (@(posedge clock) disable iff (reset)
      (pad_busy_ff && !empty) |-> (pad_pos_ff < head.width))
      else $error("padding position past field width");

endmodule

// ===== hw/rtl/utf8_to_fixed_ascii_field.sv =====
// Top level of the UTF-8 to fixed-width ASCII field converter.
`timescale 1ns / 1ps

// Takes one UTF-8 byte per cycle with no bubbles, while the output side keeps up. Every
// source byte becomes at most one field byte: ASCII passes, multibyte windows decoding
// to 0x7F or below give that value, anything else gives '?'. An end-of-field transfer
// is followed by space padding up to field_width, one output byte per cycle while
// rsp_stall is low. A four-entry command queue lets the input run ahead during padding.
// field_width 0 acts as 1 and values above MAX_WIDTH act as MAX_WIDTH; write it only
// while the block is idle.

module utf8_to_fixed_ascii_field
   import utf8f_pkg::*;
#(
   parameter int MAX_WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_field_width,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_in_byte,
   input  logic             req_has_byte,
   input  logic             req_end_of_field,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_last
);

   logic [CNT_W-1:0] width_ff;
   logic [CNT_W-1:0] eff_width;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   cmd_type          q_in;
   cmd_type          q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_write_enable) begin
         width_ff <= csr_field_width;
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         eff_width = CNT_W'(1);
      end else if ({1'b0, width_ff} > 8'(MAX_WIDTH)) begin
         eff_width = CNT_W'(MAX_WIDTH);
      end else begin
         eff_width = width_ff;
      end
   end

   utf8f_front u_front (
      .clock            (clock),
      .reset            (reset),
      .eff_width        (eff_width),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_has_byte     (req_has_byte),
      .req_end_of_field (req_end_of_field),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_in)
   );

   utf8f_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   utf8f_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .empty        (q_empty),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

// ===== tb/utf8_to_fixed_ascii_field_checker.sv =====
// Checker for utf8_to_fixed_ascii_field: predicts field bytes from input transfers and compares.
`timescale 1ns / 1ps

module utf8_to_fixed_ascii_field_checker
   import utf8f_pkg::*;
#(
   parameter int MAX_WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_field_width,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [7:0]       req_in_byte,
   input  logic             req_has_byte,
   input  logic             req_end_of_field,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [7:0]       rsp_out_byte,
   input  logic             rsp_out_last,
   output int               mismatches,
   output int               bytes_owed
);

   typedef struct packed {
      logic [7:0] chr;
      logic       last;
   } field_byte_type;

   field_byte_type   field_q[$];
   logic [CNT_W-1:0] width_reg;
   logic [1:0]       cont_left;
   logic [ACC_W-1:0] code_acc;
   logic             seq_bad;
   logic [CNT_W-1:0] written;

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic clear_field();
      cont_left = '0;
      code_acc  = '0;
      seq_bad   = 1'b0;
      written   = '0;
   endtask

   task automatic put_byte(input logic [7:0] b, input logic [CNT_W-1:0] w);
      field_byte_type fb;
      written = written + 1'b1;
      fb.chr  = b;
      fb.last = (written == w);
      field_q = {field_q, fb};
   endtask

   task automatic decode_transfer(input logic [7:0] b, input logic has, input logic eof);
      logic [CNT_W-1:0] w;
      if (width_reg == '0) w = CNT_W'(1);
      else if ({1'b0, width_reg} > 8'(MAX_WIDTH)) w = CNT_W'(MAX_WIDTH);
      else w = width_reg;
      if (has && written < w) begin
         if (cont_left == 2'd0) begin
            if (!b[7]) begin
               put_byte(b, w);
            end else if (b[7:5] == 3'b110) begin
               code_acc = ACC_W'(b[4:0]); cont_left = 2'd1; seq_bad = 1'b0;
            end else if (b[7:4] == 4'b1110) begin
               code_acc = ACC_W'(b[3:0]); cont_left = 2'd2; seq_bad = 1'b0;
            end else if (b[7:3] == 5'b11110) begin
               code_acc = ACC_W'(b[2:0]); cont_left = 2'd3; seq_bad = 1'b0;
            end else begin
               put_byte(CHAR_REPLACE, w);
            end
         end else begin
            if (b[7:6] != 2'b10) seq_bad = 1'b1;
            code_acc  = {code_acc[ACC_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0)
               put_byte((!seq_bad && code_acc <= 21'h7F) ? code_acc[7:0] : CHAR_REPLACE, w);
         end
      end
      if (eof) begin
         while (written < w) put_byte(CHAR_SPACE, w);
         clear_field();
      end
   endtask

   always @(posedge clock) begin
      field_byte_type exp_b;
      if (reset) begin
         width_reg = WIDTH_RESET;
         clear_field();
         field_q.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (field_q.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %h last %b", rsp_out_byte,
                                         rsp_out_last));
            end else begin
               exp_b = field_q.pop_front();
               if (rsp_out_byte !== exp_b.chr)
                  report_mismatch($sformatf("out_byte %h, predicted %h", rsp_out_byte,
                                            exp_b.chr));
               if (rsp_out_last !== exp_b.last)
                  report_mismatch($sformatf("out_last %b, predicted %b (byte %h)",
                                            rsp_out_last, exp_b.last, exp_b.chr));
            end
         end
         if (req_valid && !req_stall)
            decode_transfer(req_in_byte, req_has_byte, req_end_of_field);
         if (csr_write_enable) width_reg = csr_field_width;
      end
      bytes_owed <= field_q.size();
   end

endmodule

// ===== tb/utf8_to_fixed_ascii_field_tb.sv =====
// Testbench top for utf8_to_fixed_ascii_field: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module utf8_to_fixed_ascii_field_tb
   import utf8f_pkg::*;
;

   localparam int SETTLE_CYCLES = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS = 24;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [CNT_W-1:0] csr_field_width;
   logic             req_valid;
   logic             req_stall;
   logic [7:0]       req_in_byte;
   logic             req_has_byte;
   logic             req_end_of_field;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [7:0]       rsp_out_byte;
   logic             rsp_out_last;

   int   mismatches;
   int   bytes_owed;
   int   items_sent;
   int   idle_cycles;
   logic quiet;

   utf8_to_fixed_ascii_field #(.MAX_WIDTH(64)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_field_width  (csr_field_width),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_has_byte     (req_has_byte),
      .req_end_of_field (req_end_of_field),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last)
   );

   utf8_to_fixed_ascii_field_checker #(.MAX_WIDTH(64)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_field_width  (csr_field_width),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_has_byte     (req_has_byte),
      .req_end_of_field (req_end_of_field),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .mismatches       (mismatches),
      .bytes_owed       (bytes_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stall before each transfer
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = quiet ? 0 : $urandom_range(0, 3);
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("utf8_to_fixed_ascii_field: mismatch");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [7:0] b, input logic has, input logic eof);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_has_byte     <= has;
      req_end_of_field <= eof;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (bytes_owed != 0) @(negedge clock);
   endtask

   task automatic write_width(input logic [CNT_W-1:0] w);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_field_width  <= w;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // one ASCII byte, UTF-8 sequence, malformed sequence, noise or byteless transfer, maybe ending the field
   task automatic send_chunk(input int end_odds);
      logic [7:0] seq[$];
      int         kind;
      int         n;
      logic       fin;
      logic       end_alone;
      if ($urandom_range(0, 15) == 0) quiet = ~quiet;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         seq = {seq, 8'($urandom_range(0, 127))};
      end else if (kind < 85) begin
         n = (kind < 60) ? 1 : (kind < 73) ? 2 : 3;
         case (n)
            1: seq = {seq, 8'hC0 | 8'($urandom_range(0, 31))};
            2: seq = {seq, 8'hE0 | 8'($urandom_range(0, 15))};
            default: seq = {seq, 8'hF0 | 8'($urandom_range(0, 7))};
         endcase
         repeat (n) seq = {seq, 8'h80 | 8'($urandom_range(0, 63))};
      end else if (kind < 90) begin
         // overlong encodings of ASCII
         if ($urandom_range(0, 1)) begin
            seq = {seq, 8'hC0 | 8'($urandom_range(0, 1))};
         end else begin
            seq = {seq, 8'hE0};
            seq = {seq, 8'h80};
         end
         seq = {seq, 8'h80 | 8'($urandom_range(0, 63))};
      end else if (kind < 94) begin
         n = $urandom_range(1, 3);
         seq = {seq, (n == 1) ? 8'hC2 : (n == 2) ? 8'hE3 : 8'hF1};
         repeat (n) seq = {seq, 8'h80 | 8'($urandom_range(0, 63))};
         seq[$urandom_range(1, n)] = 8'($urandom_range(0, 255));
      end else if (kind < 97) begin
         seq = {seq, 8'($urandom_range(128, 255))};
      end else begin
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         return;
      end
      fin       = ($urandom_range(1, end_odds) == 1);
      end_alone = $urandom_range(0, 1);
      if (fin && seq.size() > 1 && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, seq.size() - 1);
         repeat (n) void'(seq.pop_back());
      end
      foreach (seq[i])
         send_item(seq[i], 1'b1, fin && !end_alone && i == seq.size() - 1);
      if (fin && end_alone) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      logic [CNT_W-1:0] w;
      int               phase_end;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_field_width  = '0;
      req_valid        = 1'b0;
      req_in_byte      = '0;
      req_has_byte     = 1'b0;
      req_end_of_field = 1'b0;
      quiet            = 1'b0;
      items_sent       = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset width
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'hF8, 1'b1, 1'b0);
      send_item(8'hC1, 1'b1, 1'b0);
      send_item(8'h81, 1'b1, 1'b0);
      send_item(8'hC2, 1'b1, 1'b0);
      send_item(8'hA9, 1'b1, 1'b0);
      send_item(8'hE0, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'hBF, 1'b1, 1'b0);
      send_item(8'hE2, 1'b1, 1'b0);
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h82, 1'b1, 1'b0);
      send_item(8'hF0, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h81, 1'b1, 1'b0);
      send_item(8'hF4, 1'b1, 1'b0);
      send_item(8'h8F, 1'b1, 1'b0);
      send_item(8'hBF, 1'b1, 1'b0);
      send_item(8'hBF, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'hC3, 1'b1, 1'b1);

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: w = 7'd1;
            1: w = 7'd0;
            2: w = 7'd127;
            3: w = 7'd3;
            4: w = 7'd65;
            5: w = 7'd64;
            6: w = CNT_W'($urandom_range(2, 16));
            7: w = 7'd7;
            8: w = CNT_W'($urandom_range(0, 127));
            default: w = 7'd12;
         endcase
         write_width(w);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            send_chunk((w >= 32 && w != 7'd127) || w == 7'd127 ? 40 : 8);
            if (ph == 3 && items_sent >= phase_end - PHASE_ITEMS / 2 && !quiet) begin
               drain_results();
               quiet = 1'b1;
            end
         end
         quiet = 1'b0;
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("utf8_to_fixed_ascii_field: match");
      else
         $display("utf8_to_fixed_ascii_field: mismatch");
      $finish;
   end

endmodule
